@@ rtl/lnv_pkg.sv @@
package lnv_pkg;

  localparam int unsigned LfsrW   = 15;
  localparam int unsigned TimerW  = 12;
  localparam int unsigned LengthW = 8;
  localparam int unsigned NibW    = 4;

  localparam logic [NibW-1:0] EnvTop    = 4'd15;
  localparam int unsigned     LongTap   = 1;
  localparam int unsigned     ShortTap  = 6;

  typedef enum logic [2:0] {
    ACT_WRITE    = 3'd0,
    ACT_TICK     = 3'd1,
    ACT_ENVELOPE = 3'd2,
    ACT_LENGTH   = 3'd3,
    ACT_ENABLE   = 3'd4,
    ACT_DISABLE  = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    REG_CTRL   = 2'd0,
    REG_SPARE  = 2'd1,
    REG_PERIOD = 2'd2,
    REG_LENGTH = 2'd3
  } reg_index_e;

  typedef struct packed {
    logic [NibW-1:0] sample;
    logic            length_active;
  } result_t;

  function automatic logic [TimerW-1:0] period_lookup(input logic [3:0] sel);
    logic [TimerW-1:0] p;
    case (sel)
      4'd0:    p = 12'd4;
      4'd1:    p = 12'd8;
      4'd2:    p = 12'd16;
      4'd3:    p = 12'd32;
      4'd4:    p = 12'd64;
      4'd5:    p = 12'd96;
      4'd6:    p = 12'd128;
      4'd7:    p = 12'd160;
      4'd8:    p = 12'd202;
      4'd9:    p = 12'd254;
      4'd10:   p = 12'd380;
      4'd11:   p = 12'd508;
      4'd12:   p = 12'd762;
      4'd13:   p = 12'd1016;
      4'd14:   p = 12'd2034;
      default: p = 12'd4068;
    endcase
    return p;
  endfunction

  function automatic logic [LengthW-1:0] length_lookup(input logic [4:0] sel);
    logic [LengthW-1:0] l;
    case (sel)
      5'd0:    l = 8'd10;
      5'd1:    l = 8'd254;
      5'd2:    l = 8'd20;
      5'd3:    l = 8'd2;
      5'd4:    l = 8'd40;
      5'd5:    l = 8'd4;
      5'd6:    l = 8'd80;
      5'd7:    l = 8'd6;
      5'd8:    l = 8'd160;
      5'd9:    l = 8'd8;
      5'd10:   l = 8'd60;
      5'd11:   l = 8'd10;
      5'd12:   l = 8'd14;
      5'd13:   l = 8'd12;
      5'd14:   l = 8'd26;
      5'd15:   l = 8'd14;
      5'd16:   l = 8'd12;
      5'd17:   l = 8'd16;
      5'd18:   l = 8'd24;
      5'd19:   l = 8'd18;
      5'd20:   l = 8'd48;
      5'd21:   l = 8'd20;
      5'd22:   l = 8'd96;
      5'd23:   l = 8'd22;
      5'd24:   l = 8'd192;
      5'd25:   l = 8'd24;
      5'd26:   l = 8'd72;
      5'd27:   l = 8'd26;
      5'd28:   l = 8'd16;
      5'd29:   l = 8'd28;
      5'd30:   l = 8'd32;
      default: l = 8'd30;
    endcase
    return l;
  endfunction

endpackage

@@ rtl/lfsr_noise_voice_core.sv @@
// Noise voice: 15-bit LFSR gated by a length counter, scaled by a constant
// volume or a decaying envelope.
// Input channel (in_valid_i/in_ready_o): one beat is one action - register
// write, timer tick, envelope clock, length clock, enable or disable.
// Output channel (out_valid_o/out_ready_i): exactly one beat per input beat,
// carrying the level and the length-active status after that action.
// The result is registered; it waits in the skid entry if the output is full.
// Throughput: one beat per cycle unless stalled; voice state updates in the
// same cycle an action is accepted, so back-to-back actions see each other.
// Stall: results go to an output register backed by one skid entry, so one
// more beat is taken while a result waits; in_ready_o drops only when both
// are full.
// Reset: LFSR returns to 1, all counters, flags and period clear, and the
// output buffer empties.
module lfsr_noise_voice_core
  import lnv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] action_i,
  input  logic [1:0] reg_index_i,
  input  logic [7:0] write_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] sample_o,
  output logic       length_active_o
);

  logic    push, pop;
  result_t res;
  result_t out_q, skid_q;
  logic    out_valid_q, skid_valid_q;

  assign in_ready_o = !skid_valid_q;
  assign push       = in_valid_i && in_ready_o;
  assign pop        = out_valid_q && out_ready_i;

  lnv_voice u_voice (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (push),
    .action_i     (action_i),
    .reg_index_i  (reg_index_i),
    .write_data_i (write_data_i),
    .result_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sample_o        = out_q.sample;
  assign length_active_o = out_q.length_active;

endmodule

@@ rtl/lnv_voice.sv @@
module lnv_voice
  import lnv_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [2:0]    action_i,
  input  logic [1:0]    reg_index_i,
  input  logic [7:0]    write_data_i,
  output result_t       result_o
);

  logic [LfsrW-1:0]   lfsr_q, lfsr_d;
  logic [TimerW-1:0]  tick_cnt_q, tick_cnt_d;
  logic [TimerW-1:0]  tick_per_q, tick_per_d;
  logic [LengthW-1:0] len_q, len_d;
  logic [NibW-1:0]    env_lvl_q, env_lvl_d;
  logic [NibW-1:0]    env_div_q, env_div_d;
  logic [NibW-1:0]    vol_q, vol_d;
  logic               const_vol_q, const_vol_d;
  logic               halt_q, halt_d;
  logic               short_q, short_d;
  logic               restart_q, restart_d;
  logic               fb;

  assign fb = lfsr_q[0] ^ (short_q ? lfsr_q[ShortTap] : lfsr_q[LongTap]);

  always_comb begin
    lfsr_d      = lfsr_q;
    tick_cnt_d  = tick_cnt_q;
    tick_per_d  = tick_per_q;
    len_d       = len_q;
    env_lvl_d   = env_lvl_q;
    env_div_d   = env_div_q;
    vol_d       = vol_q;
    const_vol_d = const_vol_q;
    halt_d      = halt_q;
    short_d     = short_q;
    restart_d   = restart_q;
    if (step_i) begin
      case (action_e'(action_i))
        ACT_WRITE: begin
          case (reg_index_e'(reg_index_i))
            REG_CTRL: begin
              const_vol_d = write_data_i[4];
              vol_d       = write_data_i[3:0];
              halt_d      = write_data_i[5];
            end
            REG_PERIOD: begin
              short_d    = write_data_i[7];
              tick_per_d = period_lookup(write_data_i[3:0]);
            end
            REG_LENGTH: begin
              len_d     = length_lookup(write_data_i[7:3]);
              restart_d = 1'b1;
            end
            default: ;
          endcase
        end
        ACT_TICK: begin
          if (tick_cnt_q != '0) begin
            tick_cnt_d = tick_cnt_q - 1'b1;
          end else begin
            tick_cnt_d = tick_per_q;
            lfsr_d     = {fb, lfsr_q[LfsrW-1:1]};
          end
        end
        ACT_ENVELOPE: begin
          if (restart_q) begin
            env_lvl_d = EnvTop;
            env_div_d = vol_q;
            restart_d = 1'b0;
          end else if (env_div_q != '0) begin
            env_div_d = env_div_q - 1'b1;
          end else begin
            env_div_d = vol_q;
            if (env_lvl_q != '0) begin
              env_lvl_d = env_lvl_q - 1'b1;
            end else if (halt_q) begin
              env_lvl_d = EnvTop;
            end
          end
        end
        ACT_LENGTH: begin
          if (!halt_q && len_q != '0) begin
            len_d = len_q - 1'b1;
          end
        end
        ACT_ENABLE: begin
          if ((len_q != '0 || halt_q) && restart_q) begin
            env_lvl_d = EnvTop;
            env_div_d = vol_q;
            restart_d = 1'b0;
          end
        end
        ACT_DISABLE: begin
          len_d     = '0;
          restart_d = 1'b0;
          env_lvl_d = '0;
          env_div_d = '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    result_o.length_active = (len_d != '0);
    if (len_d == '0 || lfsr_d[0]) begin
      result_o.sample = '0;
    end else begin
      result_o.sample = const_vol_d ? vol_d : env_lvl_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q      <= LfsrW'(1);
      tick_cnt_q  <= '0;
      tick_per_q  <= '0;
      len_q       <= '0;
      env_lvl_q   <= '0;
      env_div_q   <= '0;
      vol_q       <= '0;
      const_vol_q <= 1'b0;
      halt_q      <= 1'b0;
      short_q     <= 1'b0;
      restart_q   <= 1'b0;
    end else begin
      lfsr_q      <= lfsr_d;
      tick_cnt_q  <= tick_cnt_d;
      tick_per_q  <= tick_per_d;
      len_q       <= len_d;
      env_lvl_q   <= env_lvl_d;
      env_div_q   <= env_div_d;
      vol_q       <= vol_d;
      const_vol_q <= const_vol_d;
      halt_q      <= halt_d;
      short_q     <= short_d;
      restart_q   <= restart_d;
    end
  end

endmodule
